/* hdl/wsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants of the frame deframer
// Parser phases, result kinds, header length codes and the result record.
// ----------------------------------------------------------------------------
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'd0,
    PH_SECOND = 3'd1,
    PH_LEN16  = 3'd2,
    PH_LEN64  = 3'd3,
    PH_KEY    = 3'd4,
    PH_DATA   = 3'd5
  } phase_t;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [2:0] LEN16_BYTES    = 3'd2;
  localparam logic [2:0] LEN64_LAST_CNT = 3'd7;
  localparam logic [2:0] KEY_BYTES      = 3'd4;

  typedef struct packed {
    logic        result_kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [63:0] payload_length;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

endpackage

/* hdl/websocket_frame_deframer.sv */
`timescale 1ns / 1ps
// Path: an accepted byte waits in the input register, is parsed and loaded into
//   the result register once that register is free, and is taken from there.
// Throughput: one byte per cycle while the result side takes requests; a held
//   result holds every byte, header bytes too, in the input register.
// Reset: synchronous, active low; clears parser phase, byte counter, key index and the
//   valid bits of both registers. Header bytes other than the last give no result.
// ----------------------------------------------------------------------------
// websocket_frame_deframer: byte-stream frame deframer, top level
// Input register, header parser with unmasking, and result register.
// ----------------------------------------------------------------------------
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic        out_fin,
  output logic [3:0]  out_opcode,
  output logic        out_masked,
  output logic [63:0] out_payload_length,
  output logic [7:0]  out_data_byte,
  output logic        out_last
);

  logic       byte_vld;
  logic [7:0] byte_q;
  logic       advance;
  logic       out_free;
  logic       res_vld;
  result_t    res;
  result_t    out_res;

  assign advance = byte_vld & out_free;

  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .byte_vld   (byte_vld),
    .byte_q     (byte_q)
  );

  wsd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .rx_byte (byte_q),
    .res_vld (res_vld),
    .res     (res)
  );

  wsd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance & res_vld),
    .res       (res),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_vld   (out_valid),
    .out_res   (out_res)
  );

  assign out_result_kind    = out_res.result_kind;
  assign out_fin            = out_res.fin;
  assign out_opcode         = out_res.opcode;
  assign out_masked         = out_res.masked;
  assign out_payload_length = out_res.payload_length;
  assign out_data_byte      = out_res.data_byte;
  assign out_last           = out_res.last;

  a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> byte_vld)
    else $error("input stalled with empty input register");

  a_empty_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_HEADER && out_last)
      |-> (out_payload_length == 64'd0))
    else $error("header marked last with nonzero length");

  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_DATA) |-> (out_payload_length != 64'd0))
    else $error("payload byte from a zero-length frame");

  a_hdr_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res_vld && res.result_kind == KIND_HEADER)
      |=> (out_valid && out_data_byte == 8'd0))
    else $error("header result lost or carries data");

endmodule

/* hdl/wsd_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_in_reg: input byte register
// Holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module wsd_in_reg
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       advance,
  output logic       byte_vld,
  output logic [7:0] byte_q
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] byte_r;

  assign in_stall = vld_r & ~advance;
  assign byte_vld = vld_r;
  assign byte_q   = byte_r;

  always_comb begin
    vld_nxt = vld_r;
    if (in_valid && !in_stall) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

/* hdl/wsd_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_parser: frame header parser and payload unmasker
// Steps the header phase machine on each accepted byte, forms the header request and
// unmasks payload bytes with the rotating 4-byte key.
// ----------------------------------------------------------------------------
module wsd_parser
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] rx_byte,
  output logic       res_vld,
  output result_t    res
);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        fin_r, fin_nxt;
  logic [3:0]  op_r, op_nxt;
  logic        mask_r, mask_nxt;
  logic [63:0] len_r, len_nxt;
  logic [31:0] key_r, key_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic [2:0]  cnt_inc;
  logic [6:0]  small_len;
  logic        hdr_done;
  logic        len_done;
  logic [1:0]  key_sel;
  logic [7:0]  key_byte;
  logic        data_last;

  assign cnt_inc   = cnt_r + 3'd1;
  assign small_len = rx_byte[6:0];
  assign key_sel   = 2'd3 - idx_r;
  assign key_byte  = key_r[{key_sel, 3'b000} +: 8];
  assign data_last = (rem_r == 64'd1);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    fin_nxt   = fin_r;
    op_nxt    = op_r;
    mask_nxt  = mask_r;
    len_nxt   = len_r;
    key_nxt   = key_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    hdr_done  = 1'b0;
    len_done  = 1'b0;
    res_vld   = 1'b0;
    res       = '0;

    unique case (phase_r)
      PH_SECOND: begin
        mask_nxt = rx_byte[7];
        cnt_nxt  = 3'd0;
        if (small_len < LEN_CODE_EXT16) begin
          len_nxt  = {57'd0, small_len};
          len_done = 1'b1;
        end else begin
          len_nxt   = 64'd0;
          phase_nxt = (small_len == LEN_CODE_EXT16) ? PH_LEN16 : PH_LEN64;
        end
      end
      PH_LEN16: begin
        len_nxt = {len_r[55:0], rx_byte};
        cnt_nxt = cnt_inc;
        if (cnt_inc == LEN16_BYTES) begin
          len_done = 1'b1;
        end
      end
      PH_LEN64: begin
        len_nxt = {len_r[55:0], rx_byte};
        cnt_nxt = cnt_inc;
        if (cnt_r == LEN64_LAST_CNT) begin
          len_done = 1'b1;
        end
      end
      PH_KEY: begin
        key_nxt = {key_r[23:0], rx_byte};
        cnt_nxt = cnt_inc;
        if (cnt_inc == KEY_BYTES) begin
          hdr_done = 1'b1;
        end
      end
      PH_DATA: begin
        res_vld            = 1'b1;
        res.result_kind    = KIND_DATA;
        res.fin            = fin_r;
        res.opcode         = op_r;
        res.masked         = mask_r;
        res.payload_length = len_r;
        res.data_byte      = mask_r ? (rx_byte ^ key_byte) : rx_byte;
        res.last           = data_last;
        rem_nxt            = rem_r - 64'd1;
        idx_nxt            = idx_r + 2'd1;
        if (data_last) begin
          phase_nxt = PH_FIRST;
        end
      end
      default: begin
        fin_nxt   = rx_byte[7];
        op_nxt    = rx_byte[3:0];
        cnt_nxt   = 3'd0;
        phase_nxt = PH_SECOND;
      end
    endcase

    if (len_done) begin
      cnt_nxt = 3'd0;
      if (mask_nxt) begin
        phase_nxt = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      res_vld            = 1'b1;
      res.result_kind    = KIND_HEADER;
      res.fin            = fin_nxt;
      res.opcode         = op_nxt;
      res.masked         = mask_nxt;
      res.payload_length = len_nxt;
      res.data_byte      = 8'd0;
      res.last           = (len_nxt == 64'd0);
      cnt_nxt            = 3'd0;
      idx_nxt            = 2'd0;
      rem_nxt            = len_nxt;
      phase_nxt          = (len_nxt == 64'd0) ? PH_FIRST : PH_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FIRST;
      cnt_r   <= 3'd0;
      idx_r   <= 2'd0;
      fin_r   <= 1'b0;
      op_r    <= 4'd0;
      mask_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
      op_r    <= op_nxt;
      mask_r  <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      len_r <= len_nxt;
      key_r <= key_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

/* hdl/wsd_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_out_reg: result register
// Holds one result request until the receiver takes it.
// ----------------------------------------------------------------------------
module wsd_out_reg
  import wsd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  input  logic    out_stall,
  output logic    out_free,
  output logic    out_vld,
  output result_t out_res
);

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  assign out_free = ~vld_r | ~out_stall;
  assign out_vld  = vld_r;
  assign out_res  = res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (vld_r && !out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

/* tb/websocket_frame_deframer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer_test: self-checking bench for the frame deframer
// Feeds framed byte streams (all length encodings, masked and unmasked,
// random content) with random gaps and output stalls, predicts every header
// and payload result in a scoreboard and checks them in order.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_test
  import wsd_pkg::*;
();

  typedef enum logic [1:0] {ENC_SHORT, ENC_EXT16, ENC_EXT64} len_enc_t;

  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_BYTES = 650;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  class deframer_scoreboard;
    phase_t      phase;
    logic [2:0]  hdr_cnt;
    logic        fin_q;
    logic [3:0]  opc_q;
    logic        mask_q;
    logic [63:0] len_q;
    logic [31:0] key_q;
    logic [63:0] idx_q;
    result_t     expected_results[$];
    int          mismatches;

    function new();
      phase = PH_FIRST;
      hdr_cnt = '0;
      fin_q = 1'b0;
      opc_q = '0;
      mask_q = 1'b0;
      len_q = '0;
      key_q = '0;
      idx_q = '0;
      mismatches = 0;
    endfunction

    function void push_result(logic kind, logic [7:0] d, logic last);
      result_t r;
      r.result_kind = kind;
      r.fin = fin_q;
      r.opcode = opc_q;
      r.masked = mask_q;
      r.payload_length = len_q;
      r.data_byte = d;
      r.last = last;
      expected_results.push_back(r);
    endfunction

    function void header_complete();
      push_result(KIND_HEADER, 8'h00, len_q == 64'd0);
      idx_q = '0;
      hdr_cnt = '0;
      if (len_q == 64'd0) phase = PH_FIRST;
      else phase = PH_DATA;
    endfunction

    function void length_complete();
      hdr_cnt = '0;
      if (mask_q) phase = PH_KEY;
      else header_complete();
    endfunction

    // one accepted request (byte) advances the parser
    function void take_byte(logic [7:0] b);
      logic [6:0] len7;
      logic [7:0] d;
      logic       last;
      int         lane;
      case (phase)
        PH_SECOND: begin
          mask_q = b[7];
          len7 = b[6:0];
          len_q = '0;
          key_q = '0;
          hdr_cnt = '0;
          if (len7 < LEN_CODE_EXT16) begin
            len_q = {57'd0, len7};
            length_complete();
          end else if (len7 == LEN_CODE_EXT16) begin
            phase = PH_LEN16;
          end else begin
            phase = PH_LEN64;
          end
        end
        PH_LEN16, PH_LEN64: begin
          len_q = {len_q[55:0], b};
          hdr_cnt = hdr_cnt + 3'd1;
          if ((phase == PH_LEN16 && hdr_cnt == LEN16_BYTES) ||
              (phase == PH_LEN64 && hdr_cnt == 3'd0))
            length_complete();
        end
        PH_KEY: begin
          key_q = {key_q[23:0], b};
          hdr_cnt = hdr_cnt + 3'd1;
          if (hdr_cnt == KEY_BYTES) header_complete();
        end
        PH_DATA: begin
          lane = int'(idx_q[1:0]);
          d = mask_q ? (b ^ key_q[8*(3-lane) +: 8]) : b;
          last = (idx_q + 64'd1 == len_q);
          push_result(KIND_DATA, d, last);
          idx_q = idx_q + 64'd1;
          if (last) phase = PH_FIRST;
        end
        default: begin
          fin_q = b[7];
          opc_q = b[3:0];
          hdr_cnt = '0;
          phase = PH_SECOND;
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d fin=%0d op=%h mask=%0d len=%h data=%h last=%0d",
                   got.result_kind, got.fin, got.opcode, got.masked,
                   got.payload_length, got.data_byte, got.last);
        return;
      end
      want = expected_results.pop_front();
      if (got.result_kind !== want.result_kind || got.fin !== want.fin ||
          got.opcode !== want.opcode || got.masked !== want.masked ||
          got.payload_length !== want.payload_length ||
          got.data_byte !== want.data_byte || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: kind=%0d fin=%0d op=%h mask=%0d len=%h data=%h last=%0d",
                   want.result_kind, want.fin, want.opcode, want.masked,
                   want.payload_length, want.data_byte, want.last);
          $display("         got: kind=%0d fin=%0d op=%h mask=%0d len=%h data=%h last=%0d",
                   got.result_kind, got.fin, got.opcode, got.masked,
                   got.payload_length, got.data_byte, got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_result_kind;
  logic        out_fin;
  logic [3:0]  out_opcode;
  logic        out_masked;
  logic [63:0] out_payload_length;
  logic [7:0]  out_data_byte;
  logic        out_last;

  deframer_scoreboard sb = new();
  int  bytes_sent = 0;
  int  idle_cycles = 0;
  int  stall_run = 0;
  bit  in_quiet = 1'b0;

  websocket_frame_deframer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_result_kind    (out_result_kind),
    .out_fin            (out_fin),
    .out_opcode         (out_opcode),
    .out_masked         (out_masked),
    .out_payload_length (out_payload_length),
    .out_data_byte      (out_data_byte),
    .out_last           (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(result_t'({out_result_kind, out_fin, out_opcode, out_masked,
                                 out_payload_length, out_data_byte, out_last}));
  end

  // output backpressure: runs of stall / no stall, some long quiet stretches
  always @(posedge clk) begin
    int r;
    if (stall_run > 0) begin
      stall_run--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(30, 120);
      end else if (r < 60) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(0, 5);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(9, 39);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request accepted for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_byte(b);
    bytes_sent++;
    gap = in_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_rx_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] first, input logic mask,
                            input len_enc_t enc, input logic [63:0] len,
                            input logic [31:0] key, input int n_data);
    logic [6:0] code;
    send_byte(first);
    case (enc)
      ENC_SHORT: code = len[6:0];
      ENC_EXT16: code = LEN_CODE_EXT16;
      default:   code = LEN_CODE_EXT64;
    endcase
    send_byte({mask, code});
    if (enc == ENC_EXT16)
      for (int i = 1; i >= 0; i--) send_byte(len[8*i +: 8]);
    else if (enc == ENC_EXT64)
      for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    if (mask)
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    repeat (n_data) send_byte(8'($urandom));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] len;
    len_enc_t    enc;
    int          r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // zero-length ping, masked short frame, reserved bits and opcode with
    // 16-bit length, non-minimal 64-bit zero length
    send_frame(8'h89, 1'b0, ENC_SHORT, 64'd0, 32'h0, 0);
    send_frame(8'h01, 1'b1, ENC_SHORT, 64'd3, 32'hFFFF_FFFF, 3);
    send_frame(8'h7F, 1'b0, ENC_EXT16, 64'd1, 32'h0, 1);
    send_frame(8'hF0, 1'b0, ENC_EXT64, 64'd0, 32'h0, 0);
    drain_results();

    while (bytes_sent < RANDOM_BYTES) begin
      in_quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 6) begin
        case ($urandom_range(0, 4))
          0: len = 64'd125;
          1: len = 64'd126;
          2: len = 64'd127;
          3: len = 64'd200;
          default: len = 64'd300;
        endcase
      end else if (r < 22) begin
        len = 64'd0;
      end else begin
        len = 64'($urandom_range(1, 12));
      end
      r = $urandom_range(0, 9);
      if (len < 64'd126 && r < 6) enc = ENC_SHORT;
      else if (r < 8) enc = ENC_EXT16;
      else enc = ENC_EXT64;
      send_frame(8'($urandom), 1'($urandom), enc, len, $urandom, int'(len));
      if ($urandom_range(0, 19) == 0) drain_results();
    end

    // length with the top bit set: header, then a few payload bytes
    in_quiet = 1'b0;
    send_frame(8'($urandom), 1'b1, ENC_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, $urandom, 6);

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      $display("%0d expected results never arrived", sb.expected_results.size());
      sb.mismatches += sb.expected_results.size();
    end
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/wsd_pkg.sv
hdl/wsd_in_reg.sv
hdl/wsd_parser.sv
hdl/wsd_out_reg.sv
hdl/websocket_frame_deframer.sv
tb/websocket_frame_deframer_test.sv
